[hdl/fsv_pkg.sv]
package fsv_pkg;

  // Element width of the feature stream, Q4.(ELEMENT_WIDTH-4).
  localparam int ELEMENT_WIDTH = 16;
  localparam int FRAC_BITS     = ELEMENT_WIDTH - 4;
  localparam int VECTOR_LENGTH_MAX_DEF = 1024;

  // Operand width of the shared signed multiplier.
  localparam int MUL_W = 34;

  localparam int CFG_INDEX_W = 4;
  localparam logic [CFG_INDEX_W-1:0] CFG_COSINE_WEIGHT   = 4'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_DISTANCE_WEIGHT = 4'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_MATCH_THRESHOLD = 4'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_LOW_MARGIN      = 4'd3;

  localparam logic [15:0] COSINE_WEIGHT_RST   = 16'd45875;
  localparam logic [15:0] DISTANCE_WEIGHT_RST = 16'd19661;
  localparam logic [15:0] MATCH_THRESHOLD_RST = 16'd52429;
  localparam logic [15:0] LOW_MARGIN_RST      = 16'd6554;

  localparam logic [1:0] VERDICT_MATCH    = 2'd0;
  localparam logic [1:0] VERDICT_LOW_CONF = 2'd1;
  localparam logic [1:0] VERDICT_MISMATCH = 2'd2;

  // ln(2) in Q0.32.
  localparam logic [31:0] LN2_Q32 = 32'd2977044472;

  typedef struct packed {
    logic signed [ELEMENT_WIDTH-1:0] ref_element;
    logic signed [ELEMENT_WIDTH-1:0] cur_element;
    logic                            last_element;
  } in_item_t;

  typedef struct packed {
    logic [15:0] confidence;
    logic [15:0] cosine_part;
    logic [15:0] distance_part;
    logic [1:0]  verdict;
  } out_item_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_MUL_AB, ST_MUL_AA, ST_MUL_BB, ST_MUL_DD, ST_ACC_DD,
    ST_COS_CHK, ST_NORM, ST_SQRT, ST_MUL_D, ST_COS_DIV, ST_DIV,
    ST_DIST_CHK, ST_EXP_K, ST_TAY_MUL, ST_TAY_DIV, ST_Y,
    ST_MIX_C, ST_MIX_D, ST_MIX_SUM
  } fsv_state_t;

  // Which use of the shared square root or divider is in flight.
  typedef enum logic [2:0] {
    PH_S1, PH_S2, PH_COS, PH_V, PH_X, PH_TERM, PH_RES
  } fsv_phase_t;

endpackage

[hdl/feature_similarity_verdict.sv]
// Feature similarity verdict. Element pairs are requested with start while busy is low; each
// element keeps busy high while the one shared multiplier forms four products in turn, so the
// next request is not taken until that element is through. The element marked last adds the
// final computation, which runs the shared bit-serial divider (one quotient bit a cycle, up to
// 140 bits for the cosine), the shared square root and the 12-term exponential series; the
// shortest path is a zero cosine with an RMS distance of twelve or more, which skips the series.
// The result appears on out_item with out_strobe, which is high for exactly one cycle; the
// receiver cannot stall it, and busy is already low in that cycle so the next request may be
// taken. Configuration writes are always accepted and should be made only while the block is idle.
module feature_similarity_verdict #(
  parameter int VECTOR_LENGTH_MAX = fsv_pkg::VECTOR_LENGTH_MAX_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  fsv_pkg::in_item_t               in_item,
  output logic                            out_strobe,
  output fsv_pkg::out_item_t              out_item,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [fsv_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [15:0]                     cfg_data
);
  import fsv_pkg::*;

  localparam int EW    = ELEMENT_WIDTH;
  localparam int CNT_W = $clog2(VECTOR_LENGTH_MAX + 1);
  localparam int ACC_W = 2 * EW + CNT_W + 1;
  localparam int SH    = 32 - 2 * FRAC_BITS;
  localparam int SHL   = (SH > 0) ? SH : 0;
  localparam int SHR   = (SH < 0) ? -SH : 0;

  fsv_state_t state_r, state_nxt;
  fsv_phase_t phase_r, phase_nxt;

  logic [15:0] cw_r, dw_r, thr_r, mar_r;

  logic signed [EW-1:0] a_r, a_nxt, b_r, b_nxt;
  logic                 last_r, last_nxt;

  logic signed [ACC_W-1:0] dot_r, dot_nxt;
  logic [ACC_W-1:0] refe_r, refe_nxt, cure_r, cure_nxt, diffe_r, diffe_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  logic signed [MUL_W-1:0]   mul_a, mul_b;
  logic signed [2*MUL_W-1:0] prod_r;
  logic signed [EW:0]        df;

  logic [63:0] sq_v_r, sq_v_nxt, sq_r_r, sq_r_nxt, sq_b_r, sq_b_nxt;
  logic [63:0] sq_t, sq_v_step, sq_r_step;
  logic        sq_ge;
  logic [4:0]  e1_r, e1_nxt, e2_r, e2_nxt;
  logic [30:0] s1_r, s1_nxt, s2_r, s2_nxt;

  logic [63:0] div_rem_r, div_rem_nxt, div_d_r, div_d_nxt;
  logic [63:0] div_dvd_r, div_dvd_nxt, div_q_r, div_q_nxt;
  logic [63:0] div_r2, div_rem_step, div_q_step;
  logic        div_ge, div_ovf_step;
  logic [7:0]  div_cnt_r, div_cnt_nxt;
  logic        div_ovf_r, div_ovf_nxt;

  logic [15:0] cs_r, cs_nxt, ds_r, ds_nxt;
  logic [36:0] z_r, z_nxt;
  logic [37:0] ln2_sh;
  logic [5:0]  k_r, k_nxt;
  logic [2:0]  kstep_r, kstep_nxt;
  logic [32:0] term_r, term_nxt;
  logic signed [35:0] sum_r, sum_nxt;
  logic [3:0]  n_r, n_nxt;
  logic [32:0] y_c;
  logic [31:0] mixc_r, mixc_nxt;
  logic [32:0] mix_sum;
  logic [16:0] conf_c;
  logic [15:0] conf_sat, floor_t;
  logic [1:0]  verdict_c;
  logic [63:0] diff_scaled;

  out_item_t out_item_r, out_item_nxt;
  logic      out_strobe_r, out_strobe_nxt;

  assign busy       = (state_r != ST_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_strobe = out_strobe_r;
  assign out_item   = out_item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cw_r  <= COSINE_WEIGHT_RST;
      dw_r  <= DISTANCE_WEIGHT_RST;
      thr_r <= MATCH_THRESHOLD_RST;
      mar_r <= LOW_MARGIN_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_COSINE_WEIGHT:   cw_r  <= cfg_data;
        CFG_DISTANCE_WEIGHT: dw_r  <= cfg_data;
        CFG_MATCH_THRESHOLD: thr_r <= cfg_data;
        CFG_LOW_MARGIN:      mar_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Shared multiplier, registered.
  assign df = (EW+1)'(a_r) - (EW+1)'(b_r);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      ST_MUL_AB:  begin mul_a = MUL_W'(a_r); mul_b = MUL_W'(b_r); end
      ST_MUL_AA:  begin mul_a = MUL_W'(a_r); mul_b = MUL_W'(a_r); end
      ST_MUL_BB:  begin mul_a = MUL_W'(b_r); mul_b = MUL_W'(b_r); end
      ST_MUL_DD:  begin mul_a = MUL_W'(df);  mul_b = MUL_W'(df);  end
      ST_MUL_D:   begin mul_a = MUL_W'(s1_r); mul_b = MUL_W'(s2_r); end
      ST_TAY_MUL: begin mul_a = MUL_W'(term_r); mul_b = MUL_W'(z_r[31:0]); end
      ST_MIX_C:   begin mul_a = MUL_W'(cw_r); mul_b = MUL_W'(cs_r); end
      ST_MIX_D:   begin mul_a = MUL_W'(dw_r); mul_b = MUL_W'(ds_r); end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
  end

  // One step of the shared square root.
  assign sq_t      = sq_r_r + sq_b_r;
  assign sq_ge     = (sq_v_r >= sq_t);
  assign sq_v_step = sq_ge ? (sq_v_r - sq_t) : sq_v_r;
  assign sq_r_step = sq_ge ? ((sq_r_r >> 1) + sq_b_r) : (sq_r_r >> 1);

  // One step of the shared restoring divider; zeros follow the dividend bits.
  assign div_r2       = {div_rem_r[62:0], div_dvd_r[63]};
  assign div_ge       = (div_r2 >= div_d_r);
  assign div_rem_step = div_ge ? (div_r2 - div_d_r) : div_r2;
  assign div_q_step   = {div_q_r[62:0], div_ge};
  assign div_ovf_step = div_ovf_r | (div_q_step[63:16] != '0);

  assign ln2_sh      = 38'(LN2_Q32) << kstep_r;
  assign y_c         = sum_r[35] ? '0 : 33'($unsigned(sum_r) >> k_r);
  assign diff_scaled = (64'(diffe_r) << SHL) >> SHR;

  assign mix_sum   = 33'(mixc_r) + 33'(prod_r[31:0]);
  assign conf_c    = mix_sum[32:16];
  assign conf_sat  = conf_c[16] ? 16'hFFFF : conf_c[15:0];
  assign floor_t   = (thr_r > mar_r) ? (thr_r - mar_r) : '0;
  assign verdict_c = (conf_sat >= thr_r)   ? VERDICT_MATCH :
                     (conf_sat >= floor_t) ? VERDICT_LOW_CONF : VERDICT_MISMATCH;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      phase_r      <= PH_S1;
      out_strobe_r <= 1'b0;
      dot_r        <= '0;
      refe_r       <= '0;
      cure_r       <= '0;
      diffe_r      <= '0;
      cnt_r        <= '0;
    end else begin
      state_r      <= state_nxt;
      phase_r      <= phase_nxt;
      out_strobe_r <= out_strobe_nxt;
      dot_r        <= dot_nxt;
      refe_r       <= refe_nxt;
      cure_r       <= cure_nxt;
      diffe_r      <= diffe_nxt;
      cnt_r        <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r        <= a_nxt;
    b_r        <= b_nxt;
    last_r     <= last_nxt;
    sq_v_r     <= sq_v_nxt;
    sq_r_r     <= sq_r_nxt;
    sq_b_r     <= sq_b_nxt;
    e1_r       <= e1_nxt;
    e2_r       <= e2_nxt;
    s1_r       <= s1_nxt;
    s2_r       <= s2_nxt;
    div_rem_r  <= div_rem_nxt;
    div_d_r    <= div_d_nxt;
    div_dvd_r  <= div_dvd_nxt;
    div_q_r    <= div_q_nxt;
    div_cnt_r  <= div_cnt_nxt;
    div_ovf_r  <= div_ovf_nxt;
    cs_r       <= cs_nxt;
    ds_r       <= ds_nxt;
    z_r        <= z_nxt;
    k_r        <= k_nxt;
    kstep_r    <= kstep_nxt;
    term_r     <= term_nxt;
    sum_r      <= sum_nxt;
    n_r        <= n_nxt;
    mixc_r     <= mixc_nxt;
    out_item_r <= out_item_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    phase_nxt      = phase_r;
    out_strobe_nxt = 1'b0;
    a_nxt          = a_r;
    b_nxt          = b_r;
    last_nxt       = last_r;
    dot_nxt        = dot_r;
    refe_nxt       = refe_r;
    cure_nxt       = cure_r;
    diffe_nxt      = diffe_r;
    cnt_nxt        = cnt_r;
    sq_v_nxt       = sq_v_r;
    sq_r_nxt       = sq_r_r;
    sq_b_nxt       = sq_b_r;
    e1_nxt         = e1_r;
    e2_nxt         = e2_r;
    s1_nxt         = s1_r;
    s2_nxt         = s2_r;
    div_rem_nxt    = div_rem_r;
    div_d_nxt      = div_d_r;
    div_dvd_nxt    = div_dvd_r;
    div_q_nxt      = div_q_r;
    div_cnt_nxt    = div_cnt_r;
    div_ovf_nxt    = div_ovf_r;
    cs_nxt         = cs_r;
    ds_nxt         = ds_r;
    z_nxt          = z_r;
    k_nxt          = k_r;
    kstep_nxt      = kstep_r;
    term_nxt       = term_r;
    sum_nxt        = sum_r;
    n_nxt          = n_r;
    mixc_nxt       = mixc_r;
    out_item_nxt   = out_item_r;

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          a_nxt    = in_item.ref_element;
          b_nxt    = in_item.cur_element;
          last_nxt = in_item.last_element;
          // A full accumulator drops the element; a last mark still finishes.
          if (32'(cnt_r) < VECTOR_LENGTH_MAX) begin
            state_nxt = ST_MUL_AB;
          end else if (in_item.last_element) begin
            state_nxt = ST_COS_CHK;
          end
        end
      end
      ST_MUL_AB: state_nxt = ST_MUL_AA;
      ST_MUL_AA: begin
        dot_nxt   = dot_r + ACC_W'(prod_r);
        state_nxt = ST_MUL_BB;
      end
      ST_MUL_BB: begin
        refe_nxt  = refe_r + ACC_W'(prod_r);
        state_nxt = ST_MUL_DD;
      end
      ST_MUL_DD: begin
        cure_nxt  = cure_r + ACC_W'(prod_r);
        state_nxt = ST_ACC_DD;
      end
      ST_ACC_DD: begin
        diffe_nxt = diffe_r + ACC_W'(prod_r);
        cnt_nxt   = cnt_r + 1'b1;
        state_nxt = last_r ? ST_COS_CHK : ST_IDLE;
      end
      ST_COS_CHK: begin
        if (refe_r == '0 || cure_r == '0 || dot_r[ACC_W-1] || dot_r == '0) begin
          cs_nxt    = '0;
          state_nxt = ST_DIST_CHK;
        end else begin
          sq_v_nxt  = 64'(refe_r);
          e1_nxt    = '0;
          phase_nxt = PH_S1;
          state_nxt = ST_NORM;
        end
      end
      ST_NORM: begin
        // Shift the energy up two bits at a time into [2^60, 2^62).
        if (sq_v_r < (64'd1 << 60)) begin
          sq_v_nxt = sq_v_r << 2;
          if (phase_r == PH_S1) e1_nxt = e1_r + 1'b1;
          else                  e2_nxt = e2_r + 1'b1;
        end else begin
          sq_r_nxt  = '0;
          sq_b_nxt  = 64'd1 << 62;
          state_nxt = ST_SQRT;
        end
      end
      ST_SQRT: begin
        sq_v_nxt = sq_v_step;
        sq_r_nxt = sq_r_step;
        sq_b_nxt = sq_b_r >> 2;
        if (sq_b_r == 64'd1) begin
          case (phase_r)
            PH_S1: begin
              s1_nxt    = sq_r_step[30:0];
              sq_v_nxt  = 64'(cure_r);
              e2_nxt    = '0;
              phase_nxt = PH_S2;
              state_nxt = ST_NORM;
            end
            PH_S2: begin
              s2_nxt    = sq_r_step[30:0];
              state_nxt = ST_MUL_D;
            end
            default: begin
              // RMS distance in Q16.16; twelve or more gives zero.
              if (sq_r_step >= (64'd12 << 16)) begin
                ds_nxt    = '0;
                state_nxt = ST_MIX_C;
              end else begin
                z_nxt     = 37'(sq_r_step[19:0]) << 17;
                k_nxt     = '0;
                kstep_nxt = 3'd5;
                state_nxt = ST_EXP_K;
              end
            end
          endcase
        end
      end
      ST_MUL_D: state_nxt = ST_COS_DIV;
      ST_COS_DIV: begin
        div_dvd_nxt = 64'($unsigned(dot_r));
        div_d_nxt   = 64'(prod_r[61:0]);
        div_rem_nxt = '0;
        div_q_nxt   = '0;
        div_ovf_nxt = 1'b0;
        div_cnt_nxt = 8'd80 + 8'(e1_r) + 8'(e2_r);
        phase_nxt   = PH_COS;
        state_nxt   = ST_DIV;
      end
      ST_DIV: begin
        div_rem_nxt = div_rem_step;
        div_q_nxt   = div_q_step;
        div_dvd_nxt = div_dvd_r << 1;
        div_ovf_nxt = div_ovf_step;
        div_cnt_nxt = div_cnt_r - 1'b1;
        if (div_cnt_r == 8'd1) begin
          case (phase_r)
            PH_COS: begin
              cs_nxt    = div_ovf_step ? 16'hFFFF : div_q_step[15:0];
              state_nxt = ST_DIST_CHK;
            end
            PH_V: begin
              sq_v_nxt  = div_q_step;
              sq_r_nxt  = '0;
              sq_b_nxt  = 64'd1 << 62;
              phase_nxt = PH_X;
              state_nxt = ST_SQRT;
            end
            PH_TERM: begin
              term_nxt = div_q_step[32:0];
              if (n_r[0]) sum_nxt = sum_r - $signed({3'b000, div_q_step[32:0]});
              else        sum_nxt = sum_r + $signed({3'b000, div_q_step[32:0]});
              n_nxt = n_r + 1'b1;
              state_nxt = (n_r == 4'd12) ? ST_Y : ST_TAY_MUL;
            end
            default: begin
              ds_nxt    = (div_q_step[63:16] != '0) ? 16'hFFFF : div_q_step[15:0];
              state_nxt = ST_MIX_C;
            end
          endcase
        end
      end
      ST_DIST_CHK: begin
        if (cnt_r == '0) begin
          ds_nxt    = '0;
          state_nxt = ST_MIX_C;
        end else begin
          div_dvd_nxt = diff_scaled;
          div_d_nxt   = 64'(cnt_r);
          div_rem_nxt = '0;
          div_q_nxt   = '0;
          div_ovf_nxt = 1'b0;
          div_cnt_nxt = 8'd64;
          phase_nxt   = PH_V;
          state_nxt   = ST_DIV;
        end
      end
      ST_EXP_K: begin
        // 2x = k*ln2 + u, one quotient bit of k a cycle.
        if ({1'b0, z_r} >= ln2_sh) begin
          z_nxt = z_r - ln2_sh[36:0];
          k_nxt = k_r | (6'd1 << kstep_r);
        end
        kstep_nxt = kstep_r - 1'b1;
        if (kstep_r == 3'd0) begin
          term_nxt  = 33'd1 << 32;
          sum_nxt   = 36'sd1 <<< 32;
          n_nxt     = 4'd1;
          state_nxt = ST_TAY_MUL;
        end
      end
      ST_TAY_MUL: state_nxt = ST_TAY_DIV;
      ST_TAY_DIV: begin
        div_dvd_nxt = {prod_r[63:32], 32'd0};
        div_d_nxt   = 64'(n_r);
        div_rem_nxt = '0;
        div_q_nxt   = '0;
        div_ovf_nxt = 1'b0;
        div_cnt_nxt = 8'd32;
        phase_nxt   = PH_TERM;
        state_nxt   = ST_DIV;
      end
      ST_Y: begin
        // 2y/(1+y) with y = exp(-2x) in Q0.32.
        div_dvd_nxt = 64'(y_c) << 17;
        div_d_nxt   = 64'(y_c) + (64'd1 << 32);
        div_rem_nxt = '0;
        div_q_nxt   = '0;
        div_ovf_nxt = 1'b0;
        div_cnt_nxt = 8'd64;
        phase_nxt   = PH_RES;
        state_nxt   = ST_DIV;
      end
      ST_MIX_C: state_nxt = ST_MIX_D;
      ST_MIX_D: begin
        mixc_nxt  = prod_r[31:0];
        state_nxt = ST_MIX_SUM;
      end
      ST_MIX_SUM: begin
        out_item_nxt.confidence    = conf_sat;
        out_item_nxt.cosine_part   = cs_r;
        out_item_nxt.distance_part = ds_r;
        out_item_nxt.verdict       = verdict_c;
        out_strobe_nxt = 1'b1;
        dot_nxt   = '0;
        refe_nxt  = '0;
        cure_nxt  = '0;
        diffe_nxt = '0;
        cnt_nxt   = '0;
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

`ifndef NO_ASSERTIONS
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe)
    else $error("result strobe held longer than one cycle");

  a_strobe_source: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(state_r == ST_MIX_SUM))
    else $error("result strobe without final mix");

  a_verdict_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (out_item.verdict == VERDICT_MATCH ||
                    out_item.verdict == VERDICT_LOW_CONF ||
                    out_item.verdict == VERDICT_MISMATCH))
    else $error("undefined verdict code");

  a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (div_cnt_r != 8'd0))
    else $error("divider running with no bits left");

  a_accum_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (cnt_r == '0 && dot_r == '0))
    else $error("accumulators not cleared after result");
`endif

endmodule

[test/fsv_checker.sv]
module fsv_checker
  import fsv_pkg::*;
#(
  parameter int VECTOR_LENGTH_MAX = VECTOR_LENGTH_MAX_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic                   busy,
  input  in_item_t               in_item,
  input  logic                   out_strobe,
  input  out_item_t              out_item,
  input  logic                   cfg_valid,
  input  logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [15:0]            cfg_data,
  output int                     fail_count,
  output int                     verdicts_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint unsigned ONE_Q32 = 64'd4294967296;

  logic [15:0] cos_weight, dist_weight, threshold, margin;
  longint          dot_acc;
  longint unsigned ref_norm, cur_norm, diff_norm, elem_count;
  out_item_t       verdict_queue[$];

  assign verdicts_pending = verdict_queue.size();

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint unsigned scaled_root(longint unsigned n, output int unsigned e);
    e = 0;
    while (n < (64'd1 << 60)) begin
      n <<= 2;
      e++;
    end
    return int_sqrt(n);
  endfunction

  // Long division of the dot sum by the product of the normalized roots.
  function automatic longint unsigned cosine_ratio();
    int unsigned e1, e2, steps;
    longint unsigned s1, s2, d, num, r, q, bit_in;
    if (ref_norm == 0 || cur_norm == 0 || dot_acc <= 0) return 0;
    s1 = scaled_root(ref_norm, e1);
    s2 = scaled_root(cur_norm, e2);
    d = s1 * s2;
    num = longint'(dot_acc);
    steps = 64 + 16 + e1 + e2;
    r = 0;
    q = 0;
    for (int unsigned i = 0; i < steps; i++) begin
      bit_in = (i < 64) ? ((num >> (63 - i)) & 1) : 0;
      r = (r << 1) | bit_in;
      q <<= 1;
      if (r >= d) begin
        r -= d;
        q |= 1;
      end
      if (q > 64'h1FFFF) return 65535;
    end
    return (q > 65535) ? 65535 : q;
  endfunction

  // 2y/(1+y) with y = exp(-2x), x the RMS distance in Q16.16.
  function automatic longint unsigned distance_sim();
    longint unsigned v, x, z, k, u, term, y, res;
    longint sum;
    if (elem_count == 0) return 0;
    v = (diff_norm << (32 - 2 * FRAC_BITS)) / elem_count;
    x = int_sqrt(v);
    if (x >= (64'd12 << 16)) return 0;
    z = (2 * x) << 16;
    k = z / LN2_Q32;
    u = z - k * LN2_Q32;
    term = ONE_Q32;
    sum = longint'(ONE_Q32);
    for (int unsigned n = 1; n <= 12; n++) begin
      term = ((term * u) >> 32) / n;
      if (n & 1) sum -= longint'(term);
      else sum += longint'(term);
    end
    if (sum < 0) sum = 0;
    y = (k >= 63) ? 0 : (longint'(sum) >> k);
    res = ((2 * y) << 16) / (ONE_Q32 + y);
    return (res > 65535) ? 65535 : res;
  endfunction

  function automatic out_item_t finish_vector();
    out_item_t       o;
    longint unsigned cs, ds, conf, lower;
    cs = cosine_ratio();
    ds = distance_sim();
    conf = (longint'(cos_weight) * cs + longint'(dist_weight) * ds) >> 16;
    if (conf > 65535) conf = 65535;
    lower = (threshold > margin) ? threshold - margin : 0;
    o.confidence    = conf[15:0];
    o.cosine_part   = cs[15:0];
    o.distance_part = ds[15:0];
    if (conf >= threshold) o.verdict = VERDICT_MATCH;
    else if (conf >= lower) o.verdict = VERDICT_LOW_CONF;
    else o.verdict = VERDICT_MISMATCH;
    return o;
  endfunction

  always @(posedge clk) begin
    longint    a, b, df;
    out_item_t want;
    if (!rst_n) begin
      cos_weight  <= COSINE_WEIGHT_RST;
      dist_weight <= DISTANCE_WEIGHT_RST;
      threshold   <= MATCH_THRESHOLD_RST;
      margin      <= LOW_MARGIN_RST;
      dot_acc = 0;
      ref_norm = 0;
      cur_norm = 0;
      diff_norm = 0;
      elem_count = 0;
      verdict_queue.delete();
      fail_count <= 0;
    end else begin
      if (out_strobe) begin
        if (verdict_queue.size() == 0) begin
          $display("%t: unexpected result %p", $realtime, out_item);
          fail_count <= fail_count + 1;
        end else begin
          want = verdict_queue.pop_front();
          if (out_item.confidence !== want.confidence ||
              out_item.cosine_part !== want.cosine_part ||
              out_item.distance_part !== want.distance_part ||
              out_item.verdict !== want.verdict) begin
            $display("%t: mismatch expected conf=%0d cos=%0d dist=%0d verdict=%0d",
                     $realtime, want.confidence, want.cosine_part, want.distance_part,
                     want.verdict);
            $display("%t:          actual   conf=%0d cos=%0d dist=%0d verdict=%0d",
                     $realtime, out_item.confidence, out_item.cosine_part,
                     out_item.distance_part, out_item.verdict);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (start && !busy) begin
        if (elem_count < VECTOR_LENGTH_MAX) begin
          a = in_item.ref_element;
          b = in_item.cur_element;
          df = a - b;
          dot_acc += a * b;
          ref_norm += a * a;
          cur_norm += b * b;
          diff_norm += df * df;
          elem_count++;
        end
        if (in_item.last_element) begin
          verdict_queue.push_back(finish_vector());
          dot_acc = 0;
          ref_norm = 0;
          cur_norm = 0;
          diff_norm = 0;
          elem_count = 0;
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_COSINE_WEIGHT:   cos_weight  <= cfg_data;
          CFG_DISTANCE_WEIGHT: dist_weight <= cfg_data;
          CFG_MATCH_THRESHOLD: threshold   <= cfg_data;
          CFG_LOW_MARGIN:      margin      <= cfg_data;
          default: ;
        endcase
      end
    end
  end
endmodule

[test/tb.sv]
module tb;
  import fsv_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [CFG_INDEX_W-1:0] CFG_UNMAPPED = 4'd9;
  localparam longint CYCLE_LIMIT = 3000000;

  localparam int MODE_RANDOM  = 0;
  localparam int MODE_NEAR    = 1;
  localparam int MODE_TINY    = 2;

  logic                   clk = 0;
  logic                   rst_n = 0;
  logic                   start = 0;
  logic                   busy;
  in_item_t               in_item = '0;
  logic                   out_strobe;
  out_item_t              out_item;
  logic                   cfg_valid = 0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [15:0]            cfg_data = '0;
  int                     fail_count;
  int                     verdicts_pending;
  int                     idle_pct = 30;
  int                     random_sent = 0;
  longint                 cycles = 0;

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("** feature_similarity_verdict: FAILED **");
      $finish;
    end
  end

  feature_similarity_verdict dut (.*);

  fsv_checker chk (.*);

  task automatic send_element(logic signed [15:0] r, logic signed [15:0] c, logic last);
    while ($urandom_range(99) < idle_pct) begin
      start <= 0;
      @(posedge clk);
    end
    start <= 1;
    in_item <= '{ref_element: r, cur_element: c, last_element: last};
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic send_vector(int len, int mode);
    logic signed [15:0] r, c;
    for (int i = 0; i < len; i++) begin
      r = 16'($urandom);
      c = 16'($urandom);
      if (mode == MODE_NEAR) c = r + $signed(16'($urandom_range(64))) - 16'sd32;
      else if (mode == MODE_TINY) begin
        r = $signed(16'($urandom_range(15))) - 16'sd8;
        c = $signed(16'($urandom_range(15))) - 16'sd8;
      end
      send_element(r, c, i == len - 1);
    end
  endtask

  // Registers change only when no verdict is outstanding and the block has settled.
  task automatic cfg_write(logic [CFG_INDEX_W-1:0] idx, logic [15:0] val);
    start <= 0;
    @(posedge clk);
    while (verdicts_pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 0;
  endtask

  task automatic cfg_all(logic [15:0] cw, logic [15:0] dw, logic [15:0] th, logic [15:0] mg);
    cfg_write(CFG_COSINE_WEIGHT, cw);
    cfg_write(CFG_DISTANCE_WEIGHT, dw);
    cfg_write(CFG_MATCH_THRESHOLD, th);
    cfg_write(CFG_LOW_MARGIN, mg);
  endtask

  task automatic directed_set();
    send_element(-16'sd32768, -16'sd32768, 1);     // identical, exact one
    send_element(16'sd32767, -16'sd32768, 1);      // opposite extremes
    send_element(16'sd0, 16'sd0, 1);               // both norms zero
    send_element(16'sd0, 16'sd4096, 1);            // one norm zero
    send_element(16'sd4096, 16'sd4096, 0);
    send_element(-16'sd4096, -16'sd4096, 1);       // identical pair vector
    send_element(16'sd100, -16'sd200, 0);
    send_element(-16'sd300, 16'sd50, 1);           // negative dot sum
    send_element(16'sd1, 16'sd1, 0);
    send_element(16'sd1, 16'sd2, 0);
    send_element(16'sd3, 16'sd1, 1);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    directed_set();
    send_vector(4, MODE_NEAR);

    cfg_all(16'hFFFF, 16'hFFFF, 16'h0000, 16'hFFFF);
    directed_set();
    cfg_all(16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF);
    directed_set();
    cfg_all(16'h8000, 16'h8000, 16'h4000, 16'h0000);
    cfg_write(CFG_UNMAPPED, 16'h1234);
    directed_set();

    for (int ph = 0; ph < 3; ph++) begin
      idle_pct = (ph == 0) ? 30 : (ph == 1) ? 80 : 0;
      cfg_all(16'($urandom), 16'($urandom), 16'($urandom_range(65535, 30000)),
              16'($urandom_range(20000)));
      random_sent = 0;
      while (random_sent < 180) begin
        int len, mode;
        len = ($urandom_range(9) == 0) ? $urandom_range(64, 17) : $urandom_range(16, 1);
        mode = $urandom_range(2);
        send_vector(len, mode);
        random_sent += len;
      end
    end

    start <= 0;
    @(posedge clk);
    while (verdicts_pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (fail_count == 0) begin
      $display("** feature_similarity_verdict: PASSED **");
    end else begin
      $display("** feature_similarity_verdict: FAILED **");
    end
    $finish;
  end
endmodule
